### rtl/okl_pkg.sv
// okl_pkg: shared types and codes of the ordered key list engine
// holds the item, result and queue command structs and the action and status codes
// no dependencies
package okl_pkg;

  localparam int CAPACITY = 16;

  localparam logic [3:0] ACT_CLEAR     = 4'd0;
  localparam logic [3:0] ACT_INS_FRONT = 4'd1;
  localparam logic [3:0] ACT_INS_SORT  = 4'd2;
  localparam logic [3:0] ACT_INS_BACK  = 4'd3;
  localparam logic [3:0] ACT_DEL_FRONT = 4'd4;
  localparam logic [3:0] ACT_DEL_KEY   = 4'd5;
  localparam logic [3:0] ACT_DEL_BACK  = 4'd6;
  localparam logic [3:0] ACT_REVERSE   = 4'd7;
  localparam logic [3:0] ACT_PRINT     = 4'd8;
  localparam logic [3:0] ACT_NOP       = 4'd9;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] item_key;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_key;
    logic [3:0]         position;
    logic [4:0]         entry_count;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] key;
  } cmd_t;

endpackage

### rtl/okl_front.sv
// okl_front: accepts command words, classifies the action and queues them
// two-entry queue toward the back end; uses okl_pkg
module okl_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  okl_pkg::in_t item,
  output logic         busy,
  output logic         cmd_valid,
  output okl_pkg::cmd_t cmd,
  input  logic         cmd_pop
);

  okl_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  okl_pkg::cmd_t cls;

  always_comb begin
    cls.key = item.item_key;
    // unused codes become a no-op
    if (item.action > okl_pkg::ACT_PRINT) begin
      cls.op = okl_pkg::ACT_NOP;
    end else begin
      cls.op = item.action;
    end
  end

  assign busy      = (fill == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (cmd_pop) begin
        rp <= !rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

endmodule

### rtl/okl_back.sv
// okl_back: carries out queued commands on a row of key cells
// parallel compare cells, shift and rotate moves, result strobe; uses okl_pkg
module okl_back #(
  parameter int CAPACITY = okl_pkg::CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  okl_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          strobe,
  output okl_pkg::out_t result
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_ROT  = 2'd3;

  localparam logic [1:0] M_HOLD = 2'd0;
  localparam logic [1:0] M_INS  = 2'd1;
  localparam logic [1:0] M_DEL  = 2'd2;
  localparam logic [1:0] M_ROT  = 2'd3;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [IW-1:0]      step, step_next;
  logic [3:0]         op;
  logic signed [31:0] key;
  logic signed [31:0] cells [CAPACITY];
  logic signed [31:0] cells_next [CAPACITY];
  logic [CAPACITY-1:0] lt, lt_next;
  logic [CAPACITY-1:0] eq, eq_next;
  logic signed [31:0] tail, tail_next;
  logic [IW-1:0]      fz;
  logic [IW-1:0]      fe;
  logic [1:0]         mode;
  logic [IW-1:0]      p;
  logic               res_valid_next;
  okl_pkg::out_t      res_next;

  // compare cells, a less-than and an equal compare per entry
  always_comb begin
    tail_next = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      lt_next[j] = (j < int'(count)) && (cells[j] < key);
      eq_next[j] = (j < int'(count)) && (cells[j] == key);
      if (j == int'(count) - 1) begin
        tail_next = cells[j];
      end
    end
  end

  // first entry not smaller, first match
  always_comb begin
    fz = IW'(count);
    fe = '0;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (!lt[j]) begin
        fz = IW'(j);
      end
      if (eq[j]) begin
        fe = IW'(j);
      end
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    mode           = M_HOLD;
    p              = '0;
    cmd_pop        = 1'b0;
    res_valid_next = 1'b0;
    res_next       = result;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next           = S_IDLE;
        res_valid_next       = 1'b1;
        res_next.status      = okl_pkg::ST_OK;
        res_next.out_key     = '0;
        res_next.position    = '0;
        res_next.last_result = 1'b1;
        step_next            = '0;
        case (op) inside
          okl_pkg::ACT_CLEAR: begin
            count_next = '0;
          end
          okl_pkg::ACT_INS_FRONT, okl_pkg::ACT_INS_SORT, okl_pkg::ACT_INS_BACK: begin
            if (int'(count) >= CAPACITY) begin
              res_next.status = okl_pkg::ST_FULL;
            end else begin
              mode = M_INS;
              if (op == okl_pkg::ACT_INS_BACK) begin
                p = IW'(count);
              end else if (op == okl_pkg::ACT_INS_SORT) begin
                p = fz;
              end
              count_next = count + CW'(1);
            end
          end
          okl_pkg::ACT_DEL_FRONT, okl_pkg::ACT_DEL_BACK: begin
            if (count == '0) begin
              res_next.status = okl_pkg::ST_EMPTY;
            end else begin
              count_next = count - CW'(1);
              if (op == okl_pkg::ACT_DEL_FRONT) begin
                mode             = M_DEL;
                res_next.out_key = cells[0];
              end else begin
                res_next.out_key = tail;
              end
            end
          end
          okl_pkg::ACT_DEL_KEY: begin
            if (count == '0) begin
              res_next.status = okl_pkg::ST_EMPTY;
            end else if (eq == '0) begin
              res_next.status = okl_pkg::ST_NOT_FOUND;
            end else begin
              mode             = M_DEL;
              p                = fe;
              count_next       = count - CW'(1);
              res_next.out_key = key;
            end
          end
          okl_pkg::ACT_REVERSE: begin
            if (count == '0) begin
              res_next.status = okl_pkg::ST_EMPTY;
            end else if (count != CW'(1)) begin
              res_valid_next = 1'b0;
              state_next     = S_ROT;
            end
          end
          okl_pkg::ACT_PRINT: begin
            if (count == '0) begin
              res_next.status = okl_pkg::ST_EMPTY;
            end else begin
              res_valid_next = 1'b0;
              state_next     = S_ROT;
            end
          end
          default: begin
          end
        endcase
      end
      S_ROT: begin
        // move the front entry to slot p; the entries behind it up to slot p move one slot toward the front
        mode      = M_ROT;
        step_next = step + IW'(1);
        if (op == okl_pkg::ACT_PRINT) begin
          p                    = IW'(count - CW'(1));
          res_valid_next       = 1'b1;
          res_next.status      = okl_pkg::ST_OK;
          res_next.out_key     = cells[0];
          res_next.position    = 4'(step);
          res_next.last_result = (CW'(step) + CW'(1) == count);
          if (res_next.last_result) begin
            state_next = S_IDLE;
          end
        end else begin
          p = IW'(count - CW'(1) - CW'(step));
          if (CW'(step) + CW'(2) == count) begin
            res_valid_next       = 1'b1;
            res_next.status      = okl_pkg::ST_OK;
            res_next.out_key     = '0;
            res_next.position    = '0;
            res_next.last_result = 1'b1;
            state_next           = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res_next.entry_count = 5'(count_next);
  end

  // per-cell next value
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cells_next[j] = cells[j];
      case (mode)
        M_INS: begin
          if (j == int'(p)) begin
            cells_next[j] = key;
          end else if (j > int'(p)) begin
            cells_next[j] = cells[(j == 0) ? 0 : j - 1];
          end
        end
        M_DEL: begin
          if (j >= int'(p)) begin
            cells_next[j] = cells[(j == CAPACITY - 1) ? j : j + 1];
          end
        end
        M_ROT: begin
          if (j == int'(p)) begin
            cells_next[j] = cells[0];
          end else if (j < int'(p)) begin
            cells_next[j] = cells[(j == CAPACITY - 1) ? j : j + 1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      step   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      step   <= step_next;
      strobe <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      op  <= cmd.op;
      key <= cmd.key;
    end
    lt     <= lt_next;
    eq     <= eq_next;
    tail   <= tail_next;
    result <= res_next;
    for (int j = 0; j < CAPACITY; j++) begin
      cells[j] <= cells_next[j];
    end
  end

endmodule

### rtl/ordered_key_list_engine.sv
// ordered_key_list_engine: top level of the bounded ordered key list
// joins okl_front (accept and queue) and okl_back (cells and control); uses okl_pkg
//
//   channel   ports                 handshake
//   command   start, busy, item     taken when start is high and busy is low
//   result    strobe, result        each word valid for one cycle, cannot be held off
//
// an update passes the queue, the back end states S_IDLE, S_CMP and S_EXEC and the
// result register before its word appears; print gives one word each cycle, one per entry
// reverse gives a single word at its end; the back end walks the cell row one move per cycle
// the two-entry queue keeps taking commands while the back end works; busy when full
// rst is synchronous and empties the list and the queue
module ordered_key_list_engine #(
  parameter int CAPACITY = okl_pkg::CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  okl_pkg::in_t  item,
  output logic          busy,
  output logic          strobe,
  output okl_pkg::out_t result
);

  logic          cmd_valid;
  logic          cmd_pop;
  okl_pkg::cmd_t cmd;

  okl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  okl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
